### src/packed_simd_alu_64_unit_macros.svh
// ----------------------------------------------------------------------------
// Packed SIMD ALU assertion macros
// Shorthand for the concurrent checks used on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef PACKED_SIMD_ALU_64_UNIT_MACROS_SVH
`define PACKED_SIMD_ALU_64_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent, ignored while in reset.
`define PSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent, also across reset.
`define PSA_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/psa_pkg.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU package
// Operation codes, item class and the command carried from front to back.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned ACT_W  = 5;
  localparam int unsigned DATA_W = 64;

  // Operation codes
  localparam logic [ACT_W-1:0] OP_PSUBB   = 5'd0;
  localparam logic [ACT_W-1:0] OP_PADDB   = 5'd1;
  localparam logic [ACT_W-1:0] OP_PAVGB   = 5'd2;
  localparam logic [ACT_W-1:0] OP_PABSB   = 5'd3;
  localparam logic [ACT_W-1:0] OP_PMINUB  = 5'd4;
  localparam logic [ACT_W-1:0] OP_PMAXUB  = 5'd5;
  localparam logic [ACT_W-1:0] OP_PCMPEQB = 5'd6;
  localparam logic [ACT_W-1:0] OP_PCMPGTB = 5'd7;
  localparam logic [ACT_W-1:0] OP_PSUBW   = 5'd8;
  localparam logic [ACT_W-1:0] OP_PADDW   = 5'd9;
  localparam logic [ACT_W-1:0] OP_PADDSW  = 5'd10;
  localparam logic [ACT_W-1:0] OP_PSUBSW  = 5'd11;
  localparam logic [ACT_W-1:0] OP_PADDUSW = 5'd12;
  localparam logic [ACT_W-1:0] OP_PCMPGTW = 5'd13;
  localparam logic [ACT_W-1:0] OP_PCMPEQW = 5'd14;
  localparam logic [ACT_W-1:0] OP_PAVGW   = 5'd15;
  localparam logic [ACT_W-1:0] OP_PMULHW  = 5'd16;
  localparam logic [ACT_W-1:0] OP_PMULLW  = 5'd17;
  localparam logic [ACT_W-1:0] OP_PHADDSW = 5'd18;
  localparam logic [ACT_W-1:0] OP_PHSUBSW = 5'd19;

  // Saturation bounds of a signed / unsigned word lane
  localparam logic signed [15:0] SAT_MIN16  = -16'sd32768;
  localparam logic signed [15:0] SAT_MAX16  = 16'sd32767;
  localparam logic [15:0]        SAT_MAXU16 = 16'd65535;

  // Command queue between front and back (depth must be a power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_BYTE,
    CLS_WORD,
    CLS_HORIZ,
    CLS_PASS
  } op_class_t;

  typedef struct packed {
    op_class_t         cls;
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] dest;
    logic [DATA_W-1:0] src;
  } cmd_t;

  // Clamp a 17-bit signed sum to the signed word range.
  function automatic logic [15:0] clamp_s16(input logic signed [16:0] v);
    logic [15:0] r;
    if (v > 17'(SAT_MAX16)) begin
      r = SAT_MAX16;
    end else if (v < 17'(SAT_MIN16)) begin
      r = SAT_MIN16;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/psa_front.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU front end
// Accepts items, classifies the operation code and pushes a command.
// ----------------------------------------------------------------------------
module psa_front (
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [psa_pkg::ACT_W-1:0]    in_action,
  input  logic [psa_pkg::DATA_W-1:0]   in_dest_value,
  input  logic [psa_pkg::DATA_W-1:0]   in_source_value,
  input  logic                         q_full,
  output logic                         q_push,
  output psa_pkg::cmd_t                q_cmd
);
  import psa_pkg::*;

  op_class_t cls;

  // Classify the code so the back end selects a lane unit directly
  always_comb begin
    unique case (in_action) inside
      [OP_PSUBB:OP_PCMPGTB]: cls = CLS_BYTE;
      [OP_PSUBW:OP_PMULLW]:  cls = CLS_WORD;
      OP_PHADDSW, OP_PHSUBSW: cls = CLS_HORIZ;
      default:               cls = CLS_PASS;
    endcase
  end

  assign in_full       = q_full;
  assign q_push        = in_push && !q_full;
  assign q_cmd.cls     = cls;
  assign q_cmd.action  = in_action;
  assign q_cmd.dest    = in_dest_value;
  assign q_cmd.src     = in_source_value;

endmodule

### src/psa_queue.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU command queue
// Two-entry queue of decoded commands between front and back end.
// ----------------------------------------------------------------------------
module psa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psa_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output psa_pkg::cmd_t head
);
  import psa_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

### src/psa_back.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU back end
// Executes the head command lane by lane and holds results for the reader.
// ----------------------------------------------------------------------------
module psa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  psa_pkg::cmd_t              q_head,
  output logic                       q_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [psa_pkg::DATA_W-1:0] out_result_value
);
  import psa_pkg::*;

  logic [DATA_W-1:0] byte_res, word_res, horiz_res, res;
  logic [DATA_W-1:0] ob_r [QDEPTH];
  logic [QPTR_W-1:0] owp_r, owp_nxt;
  logic [QPTR_W-1:0] orp_r, orp_nxt;
  logic [QCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              o_full, do_out;

  // Byte lanes
  always_comb begin
    logic [7:0] a, b, o;
    logic [8:0] s9;
    byte_res = '0;
    for (int i = 0; i < 8; i++) begin
      a  = q_head.dest[i*8 +: 8];
      b  = q_head.src[i*8 +: 8];
      s9 = {1'b0, a} + {1'b0, b} + 9'd1;
      case (q_head.action)
        OP_PSUBB:   o = a - b;
        OP_PADDB:   o = a + b;
        OP_PAVGB:   o = s9[8:1];
        OP_PABSB:   o = b[7] ? (~b + 8'd1) : b;
        OP_PMINUB:  o = (a < b) ? a : b;
        OP_PMAXUB:  o = (a > b) ? a : b;
        OP_PCMPEQB: o = (a == b) ? 8'hFF : 8'h00;
        default:    o = ($signed(a) > $signed(b)) ? 8'hFF : 8'h00;
      endcase
      byte_res[i*8 +: 8] = o;
    end
  end

  // Word lanes, one 16x16 multiplier per lane
  always_comb begin
    logic [15:0]        a, b, o;
    logic [16:0]        usum, avg;
    logic signed [16:0] ssum, sdif;
    logic signed [31:0] prod;
    word_res = '0;
    for (int i = 0; i < 4; i++) begin
      a    = q_head.dest[i*16 +: 16];
      b    = q_head.src[i*16 +: 16];
      usum = {1'b0, a} + {1'b0, b};
      avg  = usum + 17'd1;
      ssum = {a[15], a} + {b[15], b};
      sdif = {a[15], a} - {b[15], b};
      prod = 32'($signed(a)) * 32'($signed(b));
      case (q_head.action)
        OP_PSUBW:   o = a - b;
        OP_PADDW:   o = usum[15:0];
        OP_PADDSW:  o = clamp_s16(ssum);
        OP_PSUBSW:  o = clamp_s16(sdif);
        OP_PADDUSW: o = usum[16] ? SAT_MAXU16 : usum[15:0];
        OP_PCMPGTW: o = ($signed(a) > $signed(b)) ? 16'hFFFF : 16'h0000;
        OP_PCMPEQW: o = (a == b) ? 16'hFFFF : 16'h0000;
        OP_PAVGW:   o = avg[16:1];
        OP_PMULHW:  o = prod[31:16];
        default:    o = prod[15:0];
      endcase
      word_res[i*16 +: 16] = o;
    end
  end

  // Horizontal pairs: dest pairs fill the low half, source pairs the high half
  always_comb begin
    logic [31:0]        pair;
    logic [15:0]        e, f;
    logic signed [16:0] v;
    horiz_res = '0;
    for (int i = 0; i < 4; i++) begin
      pair = (i < 2) ? q_head.dest[(i%2)*32 +: 32] : q_head.src[(i%2)*32 +: 32];
      e    = pair[15:0];
      f    = pair[31:16];
      v    = (q_head.action == OP_PHSUBSW) ? ({e[15], e} - {f[15], f})
                                           : ({e[15], e} + {f[15], f});
      horiz_res[i*16 +: 16] = clamp_s16(v);
    end
  end

  always_comb begin
    unique case (q_head.cls)
      CLS_BYTE:  res = byte_res;
      CLS_WORD:  res = word_res;
      CLS_HORIZ: res = horiz_res;
      default:   res = q_head.dest;
    endcase
  end

  // Result buffer: take a command whenever there is room
  assign o_full           = (ocnt_r == QCNT_W'(QDEPTH));
  assign out_empty        = (ocnt_r == '0);
  assign q_pop            = !q_empty && !o_full;
  assign do_out           = out_pop && !out_empty;
  assign out_result_value = ob_r[orp_r];

  always_comb begin
    owp_nxt  = q_pop ? owp_r + 1'b1 : owp_r;
    orp_nxt  = do_out ? orp_r + 1'b1 : orp_r;
    ocnt_nxt = ocnt_r + QCNT_W'(q_pop) - QCNT_W'(do_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ob_r[owp_r] <= res;
    end
  end

endmodule

### src/packed_simd_alu_64_unit.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU, 64-bit
// MMX-style packed integer ALU with queue-like handshakes on both sides.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while in_full is low: an operation code
// with a 64-bit destination and source operand, and returns one 64-bit packed
// result per item, in order. Byte ops work on eight 8-bit lanes, word ops on
// four 16-bit lanes, lane 0 in the low bits; codes 20 to 31 return the
// destination as is. A pushed item is decoded into a two-entry command queue,
// is executed into a two-entry result buffer when that has room, and shows on
// the result ports once it is registered there. Sustained rate is one item per
// cycle while the reader keeps popping; the combinational lane datapath (four
// 16x16 multipliers for the word multiplies) allows that rate. Both queues let
// the writer and reader stall independently without bubbles.
module packed_simd_alu_64_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [psa_pkg::ACT_W-1:0]  in_action,
  input  logic [psa_pkg::DATA_W-1:0] in_dest_value,
  input  logic [psa_pkg::DATA_W-1:0] in_source_value,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [psa_pkg::DATA_W-1:0] out_result_value
);
  import psa_pkg::*;

  cmd_t q_push_cmd, q_head;
  logic q_push, q_full, q_pop, q_empty;

  // Decode each item and hand it to the command queue
  psa_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_dest_value   (in_dest_value),
    .in_source_value (in_source_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_push_cmd)
  );

  // Hold decoded commands while the back end is stalled
  psa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Execute and buffer results for the reader
  psa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_result_value (out_result_value)
  );

endmodule

### src/psa_checker.sv
// ----------------------------------------------------------------------------
// Packed SIMD ALU port checker
// Port-level checks of reset state, result holding and forward progress.
// ----------------------------------------------------------------------------
`include "packed_simd_alu_64_unit_macros.svh"

module psa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_push,
  input logic                       in_full,
  input logic                       out_pop,
  input logic                       out_empty,
  input logic [psa_pkg::DATA_W-1:0] out_result_value
);
  import psa_pkg::*;

  // Reset leaves both sides drained
  `PSA_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, out_empty && !in_full, "not drained after reset")

  // A waiting result holds until popped
  `PSA_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_result_value), "result changed while waiting")

  // An item pushed while no result waits shows up once registered in the command queue and then the result buffer
  `PSA_ASSERT_NEXT(a_progress, clk, rst_n, in_push && !in_full && out_empty, ##1 !out_empty, "pushed item did not appear")

  // With the reader always popping, the input side never fills
  `PSA_ASSERT_NEXT(a_no_full, clk, rst_n, !in_full && out_pop && $past(out_pop), !in_full, "input filled while reader drains")

endmodule

bind packed_simd_alu_64_unit psa_checker u_psa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_pop          (out_pop),
  .out_empty        (out_empty),
  .out_result_value (out_result_value)
);
